/* rtl/mcpf_pkg.sv */
// Shared types, codes and default sizes for the multi-channel pipe FIFO.
`timescale 1ns / 1ps

package mcpf_pkg;

    // Default sizing
    localparam int NUM_PIPES_DEF    = 12;
    localparam int BUFFER_DEPTH_DEF = 1024;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        ACT_OPEN  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_NO_SLOT = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // Control part of one queued command
    typedef struct packed {
        status_t status;
        logic    mem_wr;
        logic    mem_rd;
    } cmd_ctrl_t;

endpackage

/* rtl/multi_channel_pipe_fifo.sv */
// Top level of the multi-channel pipe FIFO: front end, command queue, back end.
//
//   Channel | Handshake             | Beat fields
//   --------+-----------------------+-------------------------------
//   in      | in_valid / in_stall   | action, pipe_id, write_byte
//   out     | out_valid / out_stall | status, read_byte
//
// One beat in per cycle sustained while out_stall stays low, one result per beat, in order.
// The path from in to out runs through the queue entry, the byte store read and the result register.
// The front end resolves the id and updates pointers in the accept cycle; the
// byte store has one write and one registered read port, used by one beat a cycle.
// Reset clears the slot table's use flags, pointers and counts and all control state; no clearing pass is run.
// in_stall rises when the two-entry command queue is full; out_stall backs up into it.
`timescale 1ns / 1ps

module multi_channel_pipe_fifo #(
    parameter int NUM_PIPES    = mcpf_pkg::NUM_PIPES_DEF,
    parameter int BUFFER_DEPTH = mcpf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] pipe_id,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  read_byte
);

    localparam int ADDR_W = $clog2(NUM_PIPES * BUFFER_DEPTH);

    logic                q_full;
    logic                q_push;
    mcpf_pkg::cmd_ctrl_t push_ctrl;
    logic [ADDR_W-1:0]   push_addr;
    logic [7:0]          push_wdata;
    logic                q_pop;
    logic                head_valid;
    mcpf_pkg::cmd_ctrl_t head_ctrl;
    logic [ADDR_W-1:0]   head_addr;
    logic [7:0]          head_wdata;

    mcpf_front #(
        .NUM_PIPES    (NUM_PIPES),
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .pipe_id    (pipe_id),
        .write_byte (write_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctrl     (push_ctrl),
        .q_addr     (push_addr),
        .q_wdata    (push_wdata)
    );

    mcpf_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ctrl  (push_ctrl),
        .push_addr  (push_addr),
        .push_wdata (push_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_addr  (head_addr),
        .head_wdata (head_wdata)
    );

    mcpf_back #(
        .NUM_PIPES    (NUM_PIPES),
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_ctrl    (head_ctrl),
        .q_addr    (head_addr),
        .q_wdata   (head_wdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .read_byte (read_byte)
    );

endmodule

/* rtl/mcpf_ram.sv */
// Generic simple dual-port RAM with registered, enabled read.
`timescale 1ns / 1ps

module mcpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/mcpf_front.sv */
// Front end: id lookup, slot table, pointer bookkeeping and command issue.
`timescale 1ns / 1ps

module mcpf_front #(
    parameter int NUM_PIPES    = mcpf_pkg::NUM_PIPES_DEF,
    parameter int BUFFER_DEPTH = mcpf_pkg::BUFFER_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(NUM_PIPES * BUFFER_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic [31:0]           pipe_id,
    input  logic [7:0]            write_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output mcpf_pkg::cmd_ctrl_t   q_ctrl,
    output logic [ADDR_W-1:0]     q_addr,
    output logic [7:0]            q_wdata
);

    localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W  = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    // Slot table
    logic [NUM_PIPES-1:0] in_use_reg;
    logic [31:0]          id_reg  [NUM_PIPES];
    logic [PTR_W-1:0]     rp_reg  [NUM_PIPES];
    logic [PTR_W-1:0]     wp_reg  [NUM_PIPES];
    logic [CNT_W-1:0]     cnt_reg [NUM_PIPES];

    logic                 accept;
    logic [NUM_PIPES-1:0] match;
    logic                 hit;
    logic                 free_any;
    logic [SLOT_W-1:0]    hit_idx;
    logic [SLOT_W-1:0]    free_idx;
    logic [PTR_W-1:0]     cur_rp;
    logic [PTR_W-1:0]     cur_wp;
    logic [CNT_W-1:0]     cur_cnt;
    logic                 claim;
    logic                 release_slot;
    logic                 upd_en;
    logic [PTR_W-1:0]     rp_next;
    logic [PTR_W-1:0]     wp_next;
    logic [CNT_W-1:0]     cnt_next;
    logic [PTR_W-1:0]     mem_ptr;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Parallel id compare and lowest-index pick
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            match[i] = in_use_reg[i] && (id_reg[i] == pipe_id);
            if (match[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (!in_use_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
        hit      = |match;
        free_any = !(&in_use_reg);
    end

    assign cur_rp  = rp_reg[hit_idx];
    assign cur_wp  = wp_reg[hit_idx];
    assign cur_cnt = cnt_reg[hit_idx];

    // Classify the beat
    always_comb
    begin
        q_ctrl.status  = mcpf_pkg::ST_OK;
        q_ctrl.mem_wr  = 1'b0;
        q_ctrl.mem_rd  = 1'b0;
        claim          = 1'b0;
        release_slot   = 1'b0;
        upd_en         = 1'b0;
        rp_next        = cur_rp;
        wp_next        = cur_wp;
        cnt_next       = cur_cnt;
        mem_ptr        = cur_wp;
        unique case (mcpf_pkg::action_t'(action))
            mcpf_pkg::ACT_OPEN:
            begin
                if (!hit)
                begin
                    if (free_any)
                    begin
                        claim = 1'b1;
                    end
                    else
                    begin
                        q_ctrl.status = mcpf_pkg::ST_NO_SLOT;
                    end
                end
            end
            mcpf_pkg::ACT_CLOSE:
            begin
                if (hit)
                begin
                    release_slot = 1'b1;
                end
                else
                begin
                    q_ctrl.status = mcpf_pkg::ST_UNKNOWN;
                end
            end
            mcpf_pkg::ACT_WRITE:
            begin
                if (!hit)
                begin
                    q_ctrl.status = mcpf_pkg::ST_UNKNOWN;
                end
                else if (cur_cnt == CNT_W'(BUFFER_DEPTH))
                begin
                    q_ctrl.status = mcpf_pkg::ST_FULL;
                end
                else
                begin
                    q_ctrl.mem_wr = 1'b1;
                    upd_en        = 1'b1;
                    wp_next       = (cur_wp == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
                    cnt_next      = cur_cnt + 1'b1;
                end
            end
            mcpf_pkg::ACT_READ:
            begin
                mem_ptr = cur_rp;
                if (!hit)
                begin
                    q_ctrl.status = mcpf_pkg::ST_UNKNOWN;
                end
                else if (cur_cnt == '0)
                begin
                    q_ctrl.status = mcpf_pkg::ST_EMPTY;
                end
                else
                begin
                    q_ctrl.mem_rd = 1'b1;
                    upd_en        = 1'b1;
                    rp_next       = (cur_rp == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
                    cnt_next      = cur_cnt - 1'b1;
                end
            end
        endcase
    end

    // Byte address of this pipe's entry
    assign q_addr  = ADDR_W'(hit_idx) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(mem_ptr);
    assign q_wdata = write_byte;
    assign q_push  = accept;

    // Slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                rp_reg[i]  <= '0;
                wp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (claim)
            begin
                in_use_reg[free_idx] <= 1'b1;
                rp_reg[free_idx]     <= '0;
                wp_reg[free_idx]     <= '0;
                cnt_reg[free_idx]    <= '0;
            end
            if (release_slot)
            begin
                in_use_reg[hit_idx] <= 1'b0;
            end
            if (upd_en)
            begin
                rp_reg[hit_idx]  <= rp_next;
                wp_reg[hit_idx]  <= wp_next;
                cnt_reg[hit_idx] <= cnt_next;
            end
        end
    end

    // Pipe ids, meaningful only while the slot is in use
    always_ff @(posedge clk)
    begin
        if (accept && claim)
        begin
            id_reg[free_idx] <= pipe_id;
        end
    end

endmodule

/* rtl/mcpf_queue.sv */
// Short command queue between the front end and the memory back end.
`timescale 1ns / 1ps

module mcpf_queue #(
    parameter int ADDR_W = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcpf_pkg::cmd_ctrl_t push_ctrl,
    input  logic [ADDR_W-1:0]   push_addr,
    input  logic [7:0]          push_wdata,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output mcpf_pkg::cmd_ctrl_t head_ctrl,
    output logic [ADDR_W-1:0]   head_addr,
    output logic [7:0]          head_wdata
);

    mcpf_pkg::cmd_ctrl_t           ctrl_reg  [mcpf_pkg::QUEUE_DEPTH];
    logic [ADDR_W-1:0]             addr_reg  [mcpf_pkg::QUEUE_DEPTH];
    logic [7:0]                    wdata_reg [mcpf_pkg::QUEUE_DEPTH];
    logic [mcpf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mcpf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mcpf_pkg::QCNT_W-1:0]   count_reg;
    logic [mcpf_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == mcpf_pkg::QCNT_W'(mcpf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_ctrl  = ctrl_reg[rd_ptr_reg];
    assign head_addr  = addr_reg[rd_ptr_reg];
    assign head_wdata = wdata_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_reg[wr_ptr_reg]  <= push_ctrl;
            addr_reg[wr_ptr_reg]  <= push_addr;
            wdata_reg[wr_ptr_reg] <= push_wdata;
        end
    end

endmodule

/* rtl/mcpf_back.sv */
// Back end: byte store access, read data capture and result register.
`timescale 1ns / 1ps

module mcpf_back #(
    parameter int NUM_PIPES    = mcpf_pkg::NUM_PIPES_DEF,
    parameter int BUFFER_DEPTH = mcpf_pkg::BUFFER_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(NUM_PIPES * BUFFER_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mcpf_pkg::cmd_ctrl_t q_ctrl,
    input  logic [ADDR_W-1:0]   q_addr,
    input  logic [7:0]          q_wdata,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [7:0]          read_byte
);

    logic                bk_valid_reg;
    logic                bk_valid_next;
    mcpf_pkg::cmd_ctrl_t bk_ctrl_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [2:0]          status_reg;
    logic [7:0]          read_byte_reg;
    logic                move;
    logic [7:0]          ram_rdata;

    // Advance the memory stage into the result register when it is free
    assign move  = bk_valid_reg && (!out_valid_reg || !out_stall);
    assign q_pop = q_valid && (!bk_valid_reg || move);

    mcpf_ram #(
        .WIDTH (8),
        .DEPTH (NUM_PIPES * BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (q_pop && q_ctrl.mem_wr),
        .waddr (q_addr),
        .wdata (q_wdata),
        .re    (q_pop && q_ctrl.mem_rd),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        bk_valid_next = bk_valid_reg;
        if (q_pop)
        begin
            bk_valid_next = 1'b1;
        end
        else if (move)
        begin
            bk_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bk_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bk_valid_reg  <= bk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bk_ctrl_reg <= q_ctrl;
        end
        if (move)
        begin
            status_reg    <= bk_ctrl_reg.status;
            read_byte_reg <= bk_ctrl_reg.mem_rd ? ram_rdata : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_byte = read_byte_reg;

endmodule

/* rtl/mcpf_checker.sv */
// Port-level checks for the multi-channel pipe FIFO, bound to the top level.
`timescale 1ns / 1ps

module mcpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  action,
    input logic [31:0] pipe_id,
    input logic [7:0]  write_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  read_byte
);

    // Beats accepted but not yet delivered; the block holds at most four
    logic [2:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // No result without an accepted beat behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result shown with no beat outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more beats in flight than the block can hold");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == mcpf_pkg::ST_OK || status == mcpf_pkg::ST_UNKNOWN ||
                       status == mcpf_pkg::ST_NO_SLOT || status == mcpf_pkg::ST_FULL ||
                       status == mcpf_pkg::ST_EMPTY))
        else $error("status code out of range");

    a_byte_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_byte != 8'd0) |-> status == mcpf_pkg::ST_OK)
        else $error("read byte nonzero on a failed beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_byte)))
        else $error("stalled result changed");

endmodule

bind multi_channel_pipe_fifo mcpf_checker u_mcpf_checker (.*);

/* tb/tb_top.sv */
// Self-checking bench for multi_channel_pipe_fifo: predicts every status/byte result.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_PIPES    = mcpf_pkg::NUM_PIPES_DEF;
    localparam int BUFFER_DEPTH = mcpf_pkg::BUFFER_DEPTH_DEF;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int RANDOM_BEATS = 330;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        mcpf_pkg::status_t st;
        logic [7:0]        rb;
    } pipe_result_t;

    // Shadow of the slot table; holds the results still owed by the block
    class pipe_table;
        bit             used   [NUM_PIPES];
        bit [31:0]      ids    [NUM_PIPES];
        bit [PTR_W-1:0] rd_ptr [NUM_PIPES];
        bit [PTR_W-1:0] wr_ptr [NUM_PIPES];
        bit [CNT_W-1:0] fill   [NUM_PIPES];
        bit [7:0]       bytes  [NUM_PIPES][BUFFER_DEPTH];
        pipe_result_t   due_results[$];
        int             errors;

        // lowest in-use slot carrying this id
        function int lookup(bit [31:0] id);
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                if (used[i] && ids[i] == id)
                    return i;
            end
            return -1;
        endfunction

        function int first_free();
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                if (!used[i])
                    return i;
            end
            return -1;
        endfunction

        function bit [PTR_W-1:0] next_ptr(bit [PTR_W-1:0] p);
            return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        // Apply one accepted beat and queue the result it owes
        function void note_beat(mcpf_pkg::action_t act, bit [31:0] id, bit [7:0] wb);
            pipe_result_t r;
            int           s;
            int           f;
            r.st = mcpf_pkg::ST_OK;
            r.rb = 8'h00;
            s    = lookup(id);
            if (act == mcpf_pkg::ACT_OPEN)
            begin
                // an open of a live id keeps its contents
                if (s < 0)
                begin
                    f = first_free();
                    if (f < 0)
                    begin
                        r.st = mcpf_pkg::ST_NO_SLOT;
                    end
                    else
                    begin
                        used[f]   = 1'b1;
                        ids[f]    = id;
                        rd_ptr[f] = '0;
                        wr_ptr[f] = '0;
                        fill[f]   = '0;
                    end
                end
            end
            else if (s < 0)
            begin
                r.st = mcpf_pkg::ST_UNKNOWN;
            end
            else if (act == mcpf_pkg::ACT_CLOSE)
            begin
                used[s] = 1'b0;
            end
            else if (act == mcpf_pkg::ACT_WRITE)
            begin
                if (fill[s] == CNT_W'(BUFFER_DEPTH))
                begin
                    r.st = mcpf_pkg::ST_FULL;
                end
                else
                begin
                    bytes[s][wr_ptr[s]] = wb;
                    wr_ptr[s]           = next_ptr(wr_ptr[s]);
                    fill[s]             = fill[s] + 1'b1;
                end
            end
            else
            begin
                if (fill[s] == '0)
                begin
                    r.st = mcpf_pkg::ST_EMPTY;
                end
                else
                begin
                    r.rb      = bytes[s][rd_ptr[s]];
                    rd_ptr[s] = next_ptr(rd_ptr[s]);
                    fill[s]   = fill[s] - 1'b1;
                end
            end
            due_results.push_back(r);
        endfunction

        // Compare one output beat with the oldest owed result
        function void check_result(logic [2:0] st, logic [7:0] rb);
            pipe_result_t r;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, got status %0d read_byte 0x%02h",
                         $time, st, rb);
                return;
            end
            r = due_results.pop_front();
            if (st !== r.st)
            begin
                errors++;
                $display("%0t: status expected %0d (%s), got %0d",
                         $time, r.st, r.st.name(), st);
            end
            if (rb !== r.rb)
            begin
                errors++;
                $display("%0t: read_byte expected 0x%02h, got 0x%02h", $time, r.rb, rb);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] pipe_id;
    logic [7:0]  write_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [7:0]  read_byte;

    pipe_table pipes;
    bit        no_idle  = 1'b0;
    bit        hold_req = 1'b0;
    int        idle_cycles = 0;

    multi_channel_pipe_fifo dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .pipe_id    (pipe_id),
        .write_byte (write_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_byte  (read_byte)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one beat from a falling edge and hold it until accepted
    task automatic send_beat(input mcpf_pkg::action_t act, input logic [31:0] id,
                             input logic [7:0] wb);
        begin
            while (!no_idle && $urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid   <= 1'b1;
            action     <= act;
            pipe_id    <= id;
            write_byte <= wb;
            @(posedge clk);
            while (in_stall !== 1'b0)
                @(posedge clk);
            pipes.note_beat(act, id, wb);
            @(negedge clk);
        end
    endtask

    // Stop sending until every owed result has come back
    task automatic drain_pause();
        begin
            in_valid <= 1'b0;
            while (pipes.pending() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    // Output side: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= !no_idle && ($urandom_range(99) < 19);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            pipes.check_result(status, read_byte);
    end

    // Watchdog: too long without a beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [31:0]       id_pool [16];
        logic [31:0]       id;
        mcpf_pkg::action_t act;
        int                roll;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = mcpf_pkg::ACT_OPEN;
        pipe_id    = '0;
        write_byte = '0;
        pipes      = new();

        for (int i = 0; i < 11; i++)
            id_pool[i] = i * 32'h1111_1111;
        id_pool[11] = 32'hFFFF_FFFF;
        id_pool[12] = 32'h8000_0000;
        id_pool[13] = 32'h0000_0001;
        id_pool[14] = $urandom();
        id_pool[15] = $urandom();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: unknown ids, reopen, empty read, byte extremes
        send_beat(mcpf_pkg::ACT_WRITE, 32'h0, 8'h3C);
        send_beat(mcpf_pkg::ACT_READ,  32'h0, 8'h00);
        send_beat(mcpf_pkg::ACT_CLOSE, 32'h0, 8'h00);
        send_beat(mcpf_pkg::ACT_OPEN,  32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_OPEN,  32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_READ,  32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_WRITE, 32'hFFFF_FFFF, 8'hFF);
        send_beat(mcpf_pkg::ACT_WRITE, 32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_WRITE, 32'hFFFF_FFFF, 8'hA5);
        send_beat(mcpf_pkg::ACT_READ,  32'hFFFF_FFFF, 8'h00);
        // close with data left, then reopen must start empty
        send_beat(mcpf_pkg::ACT_CLOSE, 32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_READ,  32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_OPEN,  32'hFFFF_FFFF, 8'h00);
        send_beat(mcpf_pkg::ACT_READ,  32'hFFFF_FFFF, 8'h00);
        // take every slot, then one open too many
        for (int i = 0; i < NUM_PIPES - 1; i++)
            send_beat(mcpf_pkg::ACT_OPEN, id_pool[i], 8'h00);
        send_beat(mcpf_pkg::ACT_OPEN,  32'h1234_5678, 8'h00);
        send_beat(mcpf_pkg::ACT_CLOSE, id_pool[0], 8'h00);
        drain_pause();

        // Fill one pipe past full, wrap the write pointer, close it still holding data
        hold_req = 1'b1;
        send_beat(mcpf_pkg::ACT_OPEN, 32'h5A5A_C3C3, 8'h00);
        for (int k = 0; k <= BUFFER_DEPTH; k++)
            send_beat(mcpf_pkg::ACT_WRITE, 32'h5A5A_C3C3, 8'($urandom()));
        for (int k = 0; k < 10; k++)
            send_beat(mcpf_pkg::ACT_READ, 32'h5A5A_C3C3, 8'h00);
        for (int k = 0; k < 11; k++)
            send_beat(mcpf_pkg::ACT_WRITE, 32'h5A5A_C3C3, 8'($urandom()));
        send_beat(mcpf_pkg::ACT_CLOSE, 32'h5A5A_C3C3, 8'h00);
        drain_pause();

        // Random traffic over a small id pool, some stray ids mixed in
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 15)
                act = mcpf_pkg::ACT_OPEN;
            else if (roll < 23)
                act = mcpf_pkg::ACT_CLOSE;
            else if (roll < 62)
                act = mcpf_pkg::ACT_WRITE;
            else
                act = mcpf_pkg::ACT_READ;
            if (act != mcpf_pkg::ACT_OPEN && $urandom_range(9) == 0)
                id = $urandom();
            else
                id = id_pool[$urandom_range(15)];
            no_idle = (n >= 100 && n < 250);
            if (n == 40)
                hold_req = 1'b1;
            send_beat(act, id, 8'($urandom()));
        end

        // Wind down
        in_valid <= 1'b0;
        while (pipes.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pipes.errors == 0 && pipes.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
